// ===== src/spsd_pkg.sv =====
package spsd_pkg;

	localparam int HISTORY_DEPTH_DEF = 10;

	localparam int SAMPLE_W = 8;
	localparam int GAIN_W   = 16;
	localparam int ERR_W    = 9;
	localparam int DUTY_W   = 8;
	localparam int PADDR_W  = 5;
	localparam int PDATA_W  = 32;

	localparam int TURN_SPLIT   = 75;
	localparam int SCALE_DUTY   = 10000;
	localparam int RIGHT_OFFSET = 517700;
	localparam int RIGHT_SLOPE  = 1970;
	localparam int LEFT_OFFSET  = 508460;
	localparam int LEFT_SLOPE   = 1846;

	// reciprocal scaling for the divisions by constants
	localparam int MEAN_SHIFT = 16;
	localparam int DUTY_SHIFT = 22;
	localparam int DUTY_RECIP = (1 << DUTY_SHIFT) / SCALE_DUTY;

	localparam logic [7:0]  TARGET_RST   = 8'd75;
	localparam logic [15:0] PROP_RST     = 16'd256;
	localparam logic [15:0] INTEG_RST    = 16'd13;
	localparam logic [15:0] DERIV_RST    = 16'd13;
	localparam logic [7:0]  DUTY_MAX_RST = 8'd50;
	localparam logic [7:0]  DUTY_MIN_RST = 8'd25;

	typedef logic signed [ERR_W-1:0] err_t;
	typedef logic signed [9:0]       diff_t;
	typedef logic signed [23:0]      mul_a_t;
	typedef logic signed [17:0]      mul_b_t;
	typedef logic signed [41:0]      prod_t;
	typedef logic signed [27:0]      acc_t;
	typedef logic signed [19:0]      turn_t;
	typedef logic signed [32:0]      lin_t;
	typedef logic        [22:0]      lin_pos_t;

	typedef enum logic [2:0] {
		REG_TARGET   = 3'd0,
		REG_PROP     = 3'd1,
		REG_INTEG    = 3'd2,
		REG_DERIV    = 3'd3,
		REG_DUTY_MAX = 3'd4,
		REG_DUTY_MIN = 3'd5
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SUM,
		ST_MDIV,
		ST_MCOR,
		ST_P,
		ST_I,
		ST_D,
		ST_LINE,
		ST_QDIV,
		ST_QCOR,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic rd_en;
		logic wr_en;
	} hist_ctl_t;

endpackage

// ===== src/spsd_hist.sv =====
module spsd_hist #(
	parameter int HISTORY_DEPTH = spsd_pkg::HISTORY_DEPTH_DEF,
	parameter int AW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  spsd_pkg::hist_ctl_t ctl,
	input  logic [AW-1:0]       addr,
	input  spsd_pkg::err_t      wdata,
	output spsd_pkg::err_t      rdata
);

	spsd_pkg::err_t mem [HISTORY_DEPTH];
	logic [HISTORY_DEPTH-1:0] valid_q;
	spsd_pkg::err_t rd_q;
	logic rd_valid_q;

	// storage: one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem[addr] <= wdata;
		end
		if (ctl.rd_en) begin
			rd_q <= mem[addr];
		end
	end

	// a slot never written since reset reads as a zero error
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (ctl.wr_en) begin
				valid_q[addr] <= 1'b1;
			end
			if (ctl.rd_en) begin
				rd_valid_q <= valid_q[addr];
			end
		end
	end

	assign rdata = rd_valid_q ? rd_q : '0;

endmodule

// ===== src/steering_pid_servo_duty.sv =====
// A result is loaded into the output register from the output step, once the duty
// has been clamped or, when it falls inside the clamps, divided down.
// One shared 24x18 multiplier is used at most once per step, and a new sample waits
// for the whole chain to finish.
// A finished result waits in its output register while the next sample is taken.
// Reset clears the history, running sum and slot pointer; registers go to defaults.
module steering_pid_servo_duty #(
	parameter int HISTORY_DEPTH = spsd_pkg::HISTORY_DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// sample channel
	input  logic                          sample_valid,
	output logic                          sample_ready,
	input  logic [spsd_pkg::SAMPLE_W-1:0] sample,
	// result channel
	output logic                          result_valid,
	input  logic                          result_ready,
	output logic [spsd_pkg::DUTY_W-1:0]   servo_duty,
	output logic                          left_side,
	// register port
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [spsd_pkg::PADDR_W-1:0]  paddr,
	input  logic [spsd_pkg::PDATA_W-1:0]  pwdata,
	output logic [spsd_pkg::PDATA_W-1:0]  prdata,
	output logic                          pready
);

	localparam int AW         = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
	// error sum spans +/- HISTORY_DEPTH*255
	localparam int SUM_W      = $clog2(HISTORY_DEPTH * 256) + 1;
	localparam int MEAN_RECIP = (1 << spsd_pkg::MEAN_SHIFT) / HISTORY_DEPTH;

	// ---------------------------------------------------------------------------
	// Register file. Writes land on the access cycle; pready never stalls.
	// ---------------------------------------------------------------------------
	logic [7:0]  target_q;
	logic [15:0] prop_q;
	logic [15:0] integ_q;
	logic [15:0] deriv_q;
	logic [7:0]  duty_max_q;
	logic [7:0]  duty_min_q;
	logic        cfg_wr;
	spsd_pkg::reg_idx_t cfg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign cfg_idx = spsd_pkg::reg_idx_t'(paddr[4:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q   <= spsd_pkg::TARGET_RST;
			prop_q     <= spsd_pkg::PROP_RST;
			integ_q    <= spsd_pkg::INTEG_RST;
			deriv_q    <= spsd_pkg::DERIV_RST;
			duty_max_q <= spsd_pkg::DUTY_MAX_RST;
			duty_min_q <= spsd_pkg::DUTY_MIN_RST;
		end else if (cfg_wr) begin
			case (cfg_idx)
				spsd_pkg::REG_TARGET:   target_q   <= pwdata[7:0];
				spsd_pkg::REG_PROP:     prop_q     <= pwdata[15:0];
				spsd_pkg::REG_INTEG:    integ_q    <= pwdata[15:0];
				spsd_pkg::REG_DERIV:    deriv_q    <= pwdata[15:0];
				spsd_pkg::REG_DUTY_MAX: duty_max_q <= pwdata[7:0];
				spsd_pkg::REG_DUTY_MIN: duty_min_q <= pwdata[7:0];
				default: ;  // unmapped offsets drop the write
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			spsd_pkg::REG_TARGET:   prdata = {24'd0, target_q};
			spsd_pkg::REG_PROP:     prdata = {16'd0, prop_q};
			spsd_pkg::REG_INTEG:    prdata = {16'd0, integ_q};
			spsd_pkg::REG_DERIV:    prdata = {16'd0, deriv_q};
			spsd_pkg::REG_DUTY_MAX: prdata = {24'd0, duty_max_q};
			spsd_pkg::REG_DUTY_MIN: prdata = {24'd0, duty_min_q};
			default:                prdata = '0;
		endcase
	end

	// ---------------------------------------------------------------------------
	// Datapath state
	// ---------------------------------------------------------------------------
	spsd_pkg::state_t state_q, state_d;

	logic [7:0]              sample_q;
	spsd_pkg::err_t          err_q;
	logic signed [SUM_W-1:0] sum_q;
	logic [SUM_W-2:0]        abs_q;
	logic                    neg_q;
	logic [AW-1:0]           slot_q;
	logic [7:0]              qest_q;
	spsd_pkg::err_t          mean_q;
	spsd_pkg::acc_t          acc_q;
	logic                    left_q;
	spsd_pkg::lin_pos_t      lin_q;
	logic [7:0]              duty_q;
	spsd_pkg::prod_t         prod_q;

	logic                    res_valid_q;
	logic [7:0]              res_duty_q;
	logic                    res_left_q;

	// history memory
	spsd_pkg::hist_ctl_t hist_ctl;
	spsd_pkg::err_t      hist_rdata;

	spsd_hist #(
		.HISTORY_DEPTH (HISTORY_DEPTH),
		.AW            (AW)
	) u_hist (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (hist_ctl),
		.addr   (slot_q),
		.wdata  (err_q),
		.rdata  (hist_rdata)
	);

	// ---------------------------------------------------------------------------
	// Per-step combinational values
	// ---------------------------------------------------------------------------
	logic                    in_xact;
	logic                    out_load;
	spsd_pkg::err_t          err_n;
	logic signed [SUM_W-1:0] sum_n;
	logic signed [SUM_W-1:0] sum_neg;
	logic [SUM_W-2:0]        abs_n;
	logic [7:0]              mqest_n;
	logic [SUM_W-2:0]        mrem;
	logic [7:0]              mq_n;
	spsd_pkg::err_t          mean_n;
	spsd_pkg::diff_t         diff_n;
	spsd_pkg::acc_t          acc_n;
	spsd_pkg::acc_t          acc_rnd;
	spsd_pkg::turn_t         turn_n;
	logic                    left_n;
	spsd_pkg::lin_t          lin_n;
	spsd_pkg::lin_t          hi_n;
	spsd_pkg::lin_t          lo_n;
	logic                    above_hi;
	logic                    below_lo;
	logic [7:0]              dqest_n;
	spsd_pkg::lin_pos_t      drem;
	spsd_pkg::mul_a_t        mul_a;
	spsd_pkg::mul_b_t        mul_b;

	assign sample_ready = (state_q == spsd_pkg::ST_IDLE);
	assign in_xact      = sample_valid && sample_ready;
	assign out_load     = (state_q == spsd_pkg::ST_OUT) && (!res_valid_q || result_ready);

	always_comb begin
		// error of the incoming sample
		err_n   = spsd_pkg::err_t'({1'b0, sample}) - spsd_pkg::err_t'({1'b0, target_q});

		// running sum: drop the oldest error, add the newest
		sum_n   = sum_q - (SUM_W)'(hist_rdata) + (SUM_W)'(err_q);
		sum_neg = -sum_n;
		abs_n   = sum_n[SUM_W-1] ? sum_neg[SUM_W-2:0] : sum_n[SUM_W-2:0];

		// mean = trunc(sum / depth) by reciprocal plus one correction step
		mqest_n = prod_q[spsd_pkg::MEAN_SHIFT +: 8];
		mrem    = abs_q - prod_q[SUM_W-2:0];
		mq_n    = qest_q + 8'((mrem >= (SUM_W-1)'(HISTORY_DEPTH)) ? 1 : 0);
		mean_n  = neg_q ? -spsd_pkg::err_t'({1'b0, mq_n}) : spsd_pkg::err_t'({1'b0, mq_n});
		diff_n  = spsd_pkg::diff_t'(err_q) - spsd_pkg::diff_t'(mean_q);

		// turn = trunc(acc / 256) toward zero
		acc_n   = acc_q + spsd_pkg::acc_t'(prod_q);
		acc_rnd = acc_n + (acc_n[$bits(acc_n)-1] ? spsd_pkg::acc_t'(255) : '0);
		turn_n  = spsd_pkg::turn_t'(acc_rnd >>> 8);
		left_n  = turn_n > spsd_pkg::turn_t'(spsd_pkg::TURN_SPLIT);

		// duty line and clamps, in units of 1/10000
		lin_n    = (left_q ? spsd_pkg::lin_t'(spsd_pkg::LEFT_OFFSET)
		                   : spsd_pkg::lin_t'(spsd_pkg::RIGHT_OFFSET))
		           - spsd_pkg::lin_t'(prod_q);
		hi_n     = spsd_pkg::lin_t'({1'b0, duty_max_q}) * spsd_pkg::lin_t'(spsd_pkg::SCALE_DUTY);
		lo_n     = spsd_pkg::lin_t'({1'b0, duty_min_q}) * spsd_pkg::lin_t'(spsd_pkg::SCALE_DUTY);
		above_hi = lin_n > hi_n;
		below_lo = lin_n < lo_n;

		// duty = floor(v / 10000) by reciprocal plus one correction step
		dqest_n = prod_q[spsd_pkg::DUTY_SHIFT +: 8];
		drem    = lin_q - spsd_pkg::lin_pos_t'(prod_q);
	end

	// ---------------------------------------------------------------------------
	// Sequencer: next state, memory control and the shared multiplier operands
	// ---------------------------------------------------------------------------
	always_comb begin
		state_d        = state_q;
		hist_ctl.rd_en = 1'b0;
		hist_ctl.wr_en = 1'b0;
		mul_a          = '0;
		mul_b          = '0;
		case (state_q)
			spsd_pkg::ST_IDLE: begin
				// fetch the oldest error while the sample is captured
				if (in_xact) begin
					hist_ctl.rd_en = 1'b1;
					state_d        = spsd_pkg::ST_SUM;
				end
			end
			spsd_pkg::ST_SUM: begin
				hist_ctl.wr_en = 1'b1;
				mul_a          = spsd_pkg::mul_a_t'({1'b0, abs_n});
				mul_b          = spsd_pkg::mul_b_t'(MEAN_RECIP);
				state_d        = spsd_pkg::ST_MDIV;
			end
			spsd_pkg::ST_MDIV: begin
				mul_a   = spsd_pkg::mul_a_t'({1'b0, mqest_n});
				mul_b   = spsd_pkg::mul_b_t'(HISTORY_DEPTH);
				state_d = spsd_pkg::ST_MCOR;
			end
			spsd_pkg::ST_MCOR: begin
				mul_a   = spsd_pkg::mul_a_t'({1'b0, prop_q});
				mul_b   = spsd_pkg::mul_b_t'(err_q);
				state_d = spsd_pkg::ST_P;
			end
			spsd_pkg::ST_P: begin
				mul_a   = spsd_pkg::mul_a_t'({1'b0, integ_q});
				mul_b   = spsd_pkg::mul_b_t'(mean_q);
				state_d = spsd_pkg::ST_I;
			end
			spsd_pkg::ST_I: begin
				mul_a   = spsd_pkg::mul_a_t'({1'b0, deriv_q});
				mul_b   = spsd_pkg::mul_b_t'(diff_n);
				state_d = spsd_pkg::ST_D;
			end
			spsd_pkg::ST_D: begin
				mul_a   = spsd_pkg::mul_a_t'(turn_n);
				mul_b   = left_n ? spsd_pkg::mul_b_t'(spsd_pkg::LEFT_SLOPE)
				                 : spsd_pkg::mul_b_t'(spsd_pkg::RIGHT_SLOPE);
				state_d = spsd_pkg::ST_LINE;
			end
			spsd_pkg::ST_LINE: begin
				if (above_hi || below_lo) begin
					state_d = spsd_pkg::ST_OUT;
				end else begin
					mul_a   = spsd_pkg::mul_a_t'(lin_n);
					mul_b   = spsd_pkg::mul_b_t'(spsd_pkg::DUTY_RECIP);
					state_d = spsd_pkg::ST_QDIV;
				end
			end
			spsd_pkg::ST_QDIV: begin
				mul_a   = spsd_pkg::mul_a_t'({1'b0, dqest_n});
				mul_b   = spsd_pkg::mul_b_t'(spsd_pkg::SCALE_DUTY);
				state_d = spsd_pkg::ST_QCOR;
			end
			spsd_pkg::ST_QCOR: begin
				state_d = spsd_pkg::ST_OUT;
			end
			spsd_pkg::ST_OUT: begin
				// hold until the output register is free
				if (out_load) begin
					state_d = spsd_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = spsd_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= spsd_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// history bookkeeping: running sum and slot pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q  <= '0;
			slot_q <= '0;
		end else if (state_q == spsd_pkg::ST_SUM) begin
			sum_q  <= sum_n;
			slot_q <= (slot_q == AW'(HISTORY_DEPTH - 1)) ? '0 : slot_q + AW'(1);
		end
	end

	// payload registers of the working item
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		case (state_q)
			spsd_pkg::ST_IDLE: begin
				if (in_xact) begin
					sample_q <= sample;
					err_q    <= err_n;
				end
			end
			spsd_pkg::ST_SUM: begin
				abs_q <= abs_n;
				neg_q <= sum_n[SUM_W-1];
			end
			spsd_pkg::ST_MDIV: begin
				qest_q <= mqest_n;
			end
			spsd_pkg::ST_MCOR: begin
				mean_q <= mean_n;
			end
			spsd_pkg::ST_P: begin
				acc_q <= spsd_pkg::acc_t'({1'b0, sample_q, 8'd0}) + spsd_pkg::acc_t'(prod_q);
			end
			spsd_pkg::ST_I: begin
				acc_q <= acc_n;
			end
			spsd_pkg::ST_D: begin
				left_q <= left_n;
			end
			spsd_pkg::ST_LINE: begin
				if (above_hi) begin
					duty_q <= duty_max_q;
				end else if (below_lo) begin
					duty_q <= duty_min_q;
				end else begin
					lin_q <= spsd_pkg::lin_pos_t'(lin_n);
				end
			end
			spsd_pkg::ST_QDIV: begin
				duty_q <= dqest_n;
			end
			spsd_pkg::ST_QCOR: begin
				duty_q <= duty_q + 8'((drem >= spsd_pkg::lin_pos_t'(spsd_pkg::SCALE_DUTY)) ? 1 : 0);
			end
			default: ;
		endcase
	end

	// ---------------------------------------------------------------------------
	// Output register: a finished transaction waits here, the sequencer moves on
	// ---------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (out_load) begin
			res_valid_q <= 1'b1;
		end else if (result_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			res_duty_q <= duty_q;
			res_left_q <= left_q;
		end
	end

	assign result_valid = res_valid_q;
	assign servo_duty   = res_duty_q;
	assign left_side    = res_left_q;

	// ---------------------------------------------------------------------------
	// Checks
	// ---------------------------------------------------------------------------
	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		slot_q <= AW'(HISTORY_DEPTH - 1))
		else $error("history slot pointer past the last entry");

	a_write_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_xact |=> (hist_ctl.wr_en && $stable(slot_q)))
		else $error("accepted sample did not write back its error");

	a_mean_correction: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == spsd_pkg::ST_MCOR) |-> (mrem < (SUM_W-1)'(2 * HISTORY_DEPTH)))
		else $error("mean reciprocal estimate off by more than one");

	a_duty_correction: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == spsd_pkg::ST_QCOR) |->
			(drem < spsd_pkg::lin_pos_t'(2 * spsd_pkg::SCALE_DUTY)))
		else $error("duty reciprocal estimate off by more than one");

	a_load_only_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !result_ready && state_q == spsd_pkg::ST_OUT) |=>
			(state_q == spsd_pkg::ST_OUT))
		else $error("sequencer left the output step while the result was held");

endmodule

// ===== bench/steering_pid_servo_duty_tb.sv =====
`timescale 1ns / 100ps

module steering_pid_servo_duty_tb;

	// Hard stop for a hung run.
	localparam int CYCLE_LIMIT  = 300000;
	// Extra cycles after the last result before touching registers or ending.
	localparam int DRAIN_CYCLES = 14;
	// Register slots past the end of the map; writes there must be dropped.
	localparam int REG_NONE_LO  = 6;
	localparam int REG_NONE_HI  = 7;

	typedef struct {
		logic [spsd_pkg::DUTY_W-1:0] duty;
		logic                        left;
	} duty_result_t;

	// Receiver back-pressure styles, switched per phase.
	typedef enum {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_PATTERN} rx_mode_t;

	// Tracks controller state and the duty results still owed by the block.
	class duty_scoreboard_t;
		logic [7:0]  target;
		logic [15:0] kp;
		logic [15:0] ki;
		logic [15:0] kd;
		logic [7:0]  dmax;
		logic [7:0]  dmin;
		int          err_hist [spsd_pkg::HISTORY_DEPTH_DEF];
		int          err_sum;
		int          slot;
		duty_result_t owed_q [$];
		int          errors;

		function new();
			target = spsd_pkg::TARGET_RST;
			kp     = spsd_pkg::PROP_RST;
			ki     = spsd_pkg::INTEG_RST;
			kd     = spsd_pkg::DERIV_RST;
			dmax   = spsd_pkg::DUTY_MAX_RST;
			dmin   = spsd_pkg::DUTY_MIN_RST;
			foreach (err_hist[i]) err_hist[i] = 0;
			err_sum = 0;
			slot    = 0;
			errors  = 0;
		endfunction

		function void write_reg(int idx, logic [31:0] value);
			case (idx)
				spsd_pkg::REG_TARGET:   target = value[7:0];
				spsd_pkg::REG_PROP:     kp     = value[15:0];
				spsd_pkg::REG_INTEG:    ki     = value[15:0];
				spsd_pkg::REG_DERIV:    kd     = value[15:0];
				spsd_pkg::REG_DUTY_MAX: dmax   = value[7:0];
				spsd_pkg::REG_DUTY_MIN: dmin   = value[7:0];
				default: ;
			endcase
		endfunction

		function logic [31:0] reg_value(int idx);
			case (idx)
				spsd_pkg::REG_TARGET:   return {24'd0, target};
				spsd_pkg::REG_PROP:     return {16'd0, kp};
				spsd_pkg::REG_INTEG:    return {16'd0, ki};
				spsd_pkg::REG_DERIV:    return {16'd0, kd};
				spsd_pkg::REG_DUTY_MAX: return {24'd0, dmax};
				spsd_pkg::REG_DUTY_MIN: return {24'd0, dmin};
				default:                return 32'd0;
			endcase
		endfunction

		function int pending();
			return owed_q.size();
		endfunction

		// Advance the error window and work out the duty this sample yields.
		function void note_sample(logic [7:0] s);
			int           err;
			int           mean;
			longint       acc;
			longint       turn;
			longint       line;
			duty_result_t r;
			err = int'(s) - int'(target);
			err_sum = err_sum - err_hist[slot] + err;
			err_hist[slot] = err;
			slot = (slot + 1 == spsd_pkg::HISTORY_DEPTH_DEF) ? 0 : slot + 1;
			mean = err_sum / spsd_pkg::HISTORY_DEPTH_DEF;
			acc = longint'(s) * 256 + longint'(kp) * err + longint'(ki) * mean
				+ longint'(kd) * (err - mean);
			turn = acc / 256;
			r.left = turn > spsd_pkg::TURN_SPLIT;
			if (r.left) begin
				line = spsd_pkg::LEFT_OFFSET - spsd_pkg::LEFT_SLOPE * turn;
			end else begin
				line = spsd_pkg::RIGHT_OFFSET - spsd_pkg::RIGHT_SLOPE * turn;
			end
			if (line > longint'(dmax) * spsd_pkg::SCALE_DUTY) begin
				r.duty = dmax;
			end else if (line < longint'(dmin) * spsd_pkg::SCALE_DUTY) begin
				r.duty = dmin;
			end else begin
				r.duty = 8'(line / spsd_pkg::SCALE_DUTY);
			end
			owed_q.push_back(r);
		endfunction

		function void check_result(logic [7:0] duty, logic left);
			duty_result_t r;
			if (owed_q.size() == 0) begin
				$display("%0t: unexpected result duty %0d left_side %0b", $time, duty, left);
				errors++;
				return;
			end
			r = owed_q.pop_front();
			if (duty !== r.duty) begin
				$display("%0t: servo_duty expected %0d actual %0d", $time, r.duty, duty);
				errors++;
			end
			if (left !== r.left) begin
				$display("%0t: left_side expected %0b actual %0b", $time, r.left, left);
				errors++;
			end
		endfunction
	endclass

	logic                          clk = 1'b0;
	logic                          arst_n;
	logic                          sample_valid;
	logic                          sample_ready;
	logic [spsd_pkg::SAMPLE_W-1:0] sample;
	logic                          result_valid;
	logic                          result_ready = 1'b1;
	logic [spsd_pkg::DUTY_W-1:0]   servo_duty;
	logic                          left_side;
	logic                          psel;
	logic                          penable;
	logic                          pwrite;
	logic [spsd_pkg::PADDR_W-1:0]  paddr;
	logic [spsd_pkg::PDATA_W-1:0]  pwdata;
	logic [spsd_pkg::PDATA_W-1:0]  prdata;
	logic                          pready;

	duty_scoreboard_t sb = new();
	rx_mode_t       rx_mode = RX_OPEN;
	int             rx_beat = 0;
	int             rx_hold = 0;
	int             cycles;
	logic [7:0]     script_q [$];

	steering_pid_servo_duty dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.sample       (sample),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.servo_duty   (servo_duty),
		.left_side    (left_side),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Receiver: RX_OPEN keeps result_ready high; each other mode stalls it on a pattern of its own.
	always @(posedge clk) begin
		rx_beat <= rx_beat + 1;
		case (rx_mode)
			RX_OPEN:    result_ready <= 1'b1;
			RX_PATTERN: result_ready <= (rx_beat % 8) < 5;
			default: begin
				if (rx_hold > 0) begin
					result_ready <= 1'b0;
					rx_hold <= rx_hold - 1;
				end else if ($urandom_range(0, rx_mode == RX_LIGHT ? 15 : 2) == 0) begin
					result_ready <= 1'b0;
					rx_hold <= $urandom_range(0, rx_mode == RX_LIGHT ? 3 : 14);
				end else begin
					result_ready <= 1'b1;
				end
			end
		endcase
	end

	// Monitor: values seen here are the ones the block saw at this edge.
	// Check the result first; a sample taken on the same edge cannot own it.
	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid && result_ready) sb.check_result(servo_duty, left_side);
			if (sample_valid && sample_ready) sb.note_sample(sample);
		end
	end

	// Watchdog: count cycles and give up if the run hangs.
	initial begin
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("DONE: errors detected");
		$finish;
	end

	function automatic logic [31:0] reg_mask(int idx);
		if (idx == spsd_pkg::REG_PROP || idx == spsd_pkg::REG_INTEG
				|| idx == spsd_pkg::REG_DERIV) return 32'h0000_FFFF;
		return 32'h0000_00FF;
	endfunction

	// Samples near the target so the loop settles and full-range noise in equal
	// measure, plus the field extremes and the line split points.
	function automatic logic [7:0] pick_sample();
		int pick;
		int near;
		pick = $urandom_range(0, 9);
		if (pick < 4) return 8'($urandom_range(0, 255));
		if (pick < 8) begin
			near = int'(sb.target) + int'($urandom_range(0, 24)) - 12;
			if (near < 0) near = 0;
			if (near > 255) near = 255;
			return 8'(near);
		end
		case ($urandom_range(0, 3))
			0:       return 8'd0;
			1:       return 8'd255;
			2:       return 8'(spsd_pkg::TURN_SPLIT);
			default: return 8'(spsd_pkg::TURN_SPLIT + 1);
		endcase
	endfunction

	function automatic logic [15:0] pick_gain();
		case ($urandom_range(0, 5))
			0:       return 16'd0;
			1:       return 16'hFFFF;
			2:       return 16'($urandom_range(0, 65535));
			default: return 16'($urandom_range(0, 1024));
		endcase
	endfunction

	// APB write: setup, access, then an idle step so psel drops cleanly.
	task automatic reg_write(int idx, logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= spsd_pkg::PADDR_W'(idx * 4);
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.write_reg(idx, value);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// APB read of one register, compared against the tracked value.
	task automatic reg_check(int idx);
		logic [31:0] got;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= spsd_pkg::PADDR_W'(idx * 4);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		got = prdata;
		if ((got & reg_mask(idx)) !== sb.reg_value(idx)) begin
			$display("%0t: register %0d expected %0h actual %0h", $time, idx,
				sb.reg_value(idx), got & reg_mask(idx));
			sb.errors++;
		end
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// Write all six registers, optionally with junk above each field, then read back.
	task automatic load_config(logic [7:0] tgt, logic [15:0] p, logic [15:0] i,
			logic [15:0] d, logic [7:0] hi, logic [7:0] lo, bit noisy);
		logic [31:0] vals [6];
		vals[spsd_pkg::REG_TARGET]   = {24'd0, tgt};
		vals[spsd_pkg::REG_PROP]     = {16'd0, p};
		vals[spsd_pkg::REG_INTEG]    = {16'd0, i};
		vals[spsd_pkg::REG_DERIV]    = {16'd0, d};
		vals[spsd_pkg::REG_DUTY_MAX] = {24'd0, hi};
		vals[spsd_pkg::REG_DUTY_MIN] = {24'd0, lo};
		for (int k = 0; k < 6; k++) begin
			reg_write(k, noisy ? (vals[k] | ($urandom & ~reg_mask(k))) : vals[k]);
		end
		for (int k = 0; k < 6; k++) reg_check(k);
	endtask

	// Hold valid and payload until the block takes the transaction.
	task automatic send_sample(logic [7:0] value);
		sample       <= value;
		sample_valid <= 1'b1;
		do @(posedge clk); while (!sample_ready);
	endtask

	// Send a stream of samples: scripted ones first, random after that.
	// With gaps on, the sender works in bursts split by idle stretches.
	task automatic run_stream(int count, bit gaps);
		int burst;
		int gap;
		burst = $urandom_range(1, 24);
		for (int n = 0; n < count; n++) begin
			if (script_q.size() > 0) send_sample(script_q.pop_front());
			else send_sample(pick_sample());
			burst--;
			if (n == count - 1) begin
				sample_valid <= 1'b0;
			end else if (gaps && burst == 0) begin
				sample_valid <= 1'b0;
				sample       <= 8'($urandom);
				gap = $urandom_range(1, 8);
				repeat (gap) @(posedge clk);
				burst = $urandom_range(1, 24);
			end
		end
	endtask

	// Wait for every owed result, then let the pipeline settle.
	task automatic drain();
		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic random_config();
		logic [7:0] hi;
		logic [7:0] lo;
		logic [7:0] swap;
		lo = 8'($urandom_range(0, 60));
		hi = 8'(lo + $urandom_range(0, 80));
		case ($urandom_range(0, 5))
			0: begin
				hi = 8'd255;
				lo = 8'd0;
			end
			1: begin
				// crossed clamps: the upper bound wins where both apply
				swap = hi;
				hi   = lo;
				lo   = swap;
			end
			default: ;
		endcase
		load_config(8'($urandom_range(0, 255)), pick_gain(), pick_gain(), pick_gain(),
			hi, lo, 1'b1);
	endtask

	initial begin
		arst_n       <= 1'b0;
		sample_valid <= 1'b0;
		sample       <= '0;
		psel         <= 1'b0;
		penable      <= 1'b0;
		pwrite       <= 1'b0;
		paddr        <= '0;
		pwdata       <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset values, empty history: field extremes and the split points.
		script_q = '{8'd0, 8'd255, 8'd75, 8'd74, 8'd76, 8'd1, 8'd254, 8'h55, 8'hAA,
			8'd128, 8'd127};
		run_stream(script_q.size(), 1'b0);
		drain();

		// Writes past the register map must leave everything unchanged.
		reg_write(REG_NONE_LO, 32'hFFFF_FFFF);
		reg_write(REG_NONE_HI, 32'hFFFF_FFFF);
		for (int k = 0; k < 6; k++) reg_check(k);

		// Maximum gains, widest clamps: turn runs far outside both lines.
		load_config(8'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'd255, 8'd0, 1'b0);
		rx_mode = RX_HEAVY;
		script_q = '{8'd255, 8'd0, 8'd255, 8'd128};
		run_stream(script_q.size(), 1'b1);
		drain();

		// Zero gains, top target, crossed clamps.
		load_config(8'd255, 16'd0, 16'd0, 16'd0, 8'd0, 8'd255, 1'b0);
		rx_mode = RX_PATTERN;
		script_q = '{8'd0, 8'd255, 8'd200};
		run_stream(script_q.size(), 1'b0);
		drain();

		// Zero gains, zero target: turn equals the sample; probe the line split.
		load_config(8'd0, 16'd0, 16'd0, 16'd0, 8'd255, 8'd0, 1'b0);
		rx_mode = RX_LIGHT;
		script_q = '{8'd75, 8'd76, 8'd0, 8'd255, 8'd10};
		run_stream(script_q.size(), 1'b1);
		drain();

		// Random phases: new settings each time, receiver style rotates.
		for (int ph = 0; ph < 6; ph++) begin
			random_config();
			rx_mode = rx_mode_t'(ph % 4);
			if (ph == 3) begin
				// hold the sender until every owed result has come back
				run_stream(75, 1'b1);
				while (sb.pending() != 0) @(posedge clk);
				run_stream(75, 1'b1);
			end else begin
				run_stream(150, ph != 1);
			end
			drain();
		end

		if (sb.errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
